// File: src/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Types and constants for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;

  localparam int SET_COUNT = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1) > 4 ? $clog2(MAX_WAYS + 1) : 4;
  localparam int LEAVES    = 1 << WAY_W;

  localparam int ADDR_W  = 64;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;

  // opcodes
  localparam logic [1:0] OP_FETCH  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_IGNORED = 2'd0;
  localparam logic [1:0] OUT_HIT     = 2'd1;
  localparam logic [1:0] OUT_FILL    = 2'd2;
  localparam logic [1:0] OUT_EVICT   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
  } cache_in_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             extra_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } cache_out_t;

  // one set: all ways side by side
  typedef struct packed {
    logic [MAX_WAYS-1:0]               valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]   tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]  stamp;
  } set_row_t;

endpackage

// File: src/set_assoc_lru_cache_model_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_core
// Set-associative cache model with LRU replacement and running totals.
// ----------------------------------------------------------------------------
// At transfer the indexed set is read from the set memory into a register;
// in the lookup state the core checks all ways, picks the victim through a
// stamp-compare tree and writes the set back while the result is registered.
// Lookup holds while an earlier result waits to be taken. The single
// read-modify-write on the set memory keeps out a new access until the lookup
// is done; a new access is taken while a result still waits. Sets that were
// never written read as all zero through one valid flop per set, so there is
// no clearing pass after reset. Fetches take the same path and change nothing.
module set_assoc_lru_cache_model_core
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cache_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cache_out_t            out_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic state_r, state_nxt;

  logic [3:0] set_bits_r;
  logic [3:0] ways_r;
  logic [5:0] block_bits_r;

  logic [STAMP_W-1:0] clk_cnt_r;
  logic [CNT_W-1:0]   hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [STAMP_W-1:0] clk_cnt_nxt;
  logic [CNT_W-1:0]   hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;

  logic              out_valid_r;
  cache_out_t        out_data_r;

  logic [1:0]        op_r;
  logic [SET_W-1:0]  idx_r;
  logic [ADDR_W-1:0] tag_r;

  set_row_t          mem [SET_COUNT];
  logic [SET_COUNT-1:0] row_vld_r;
  set_row_t          rd_r;
  logic              rv_r;

  logic in_xfer, adv, mem_we;

  // --------------------------------------------------------------------------
  // address split at transfer
  // --------------------------------------------------------------------------
  logic [3:0]        sb;
  logic [6:0]        tshift;
  logic [ADDR_W-1:0] addr_sh;
  logic [SET_W-1:0]  set_idx;
  logic [ADDR_W-1:0] tag_in;

  always_comb begin
    sb      = (set_bits_r > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_r;
    tshift  = {3'b000, sb} + {1'b0, block_bits_r};
    addr_sh = in_data.address >> block_bits_r;
    set_idx = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
    tag_in  = (tshift >= 7'd64) ? '0 : (in_data.address >> tshift);
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign adv      = (state_r == S_LOOK) && (!out_valid_r || out_ready);
  assign mem_we   = adv && (op_r != OP_FETCH);

  // --------------------------------------------------------------------------
  // set lookup
  // --------------------------------------------------------------------------
  set_row_t             row, row_nxt;
  logic [WCNT_W-1:0]    wn;
  logic [MAX_WAYS-1:0]  in_use, match, empty;
  logic                 found, any_empty;
  logic [WAY_W-1:0]     hit_way, empty_way, lru_way, fill_way;

  // LRU tree over stamps, heap-ordered: node i has children 2i and 2i+1
  logic [2*LEAVES-1:0]              nd_en;
  logic [2*LEAVES-1:0][STAMP_W-1:0] nd_st;
  logic [2*LEAVES-1:0][WAY_W-1:0]   nd_ix;

  always_comb begin
    row = rv_r ? rd_r : '0;
    wn  = WCNT_W'(ways_r);
    if (wn == '0) wn = WCNT_W'(1);
    if (wn > WCNT_W'(MAX_WAYS)) wn = WCNT_W'(MAX_WAYS);

    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (WCNT_W'(w) < wn);
      match[w]  = in_use[w] && row.valid[w] && (row.tag[w] == tag_r);
      empty[w]  = in_use[w] && !row.valid[w];
    end
    found     = |match;
    any_empty = |empty;

    hit_way   = '0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (empty[w]) empty_way = WAY_W'(w);
    end

    nd_en = '0;
    nd_st = '0;
    nd_ix = '0;
    for (int w = 0; w < LEAVES; w++) begin
      if (w < MAX_WAYS) begin
        nd_en[LEAVES + w] = in_use[w];
        nd_st[LEAVES + w] = row.stamp[w];
      end
      nd_ix[LEAVES + w] = WAY_W'(w);
    end
    for (int i = LEAVES - 1; i >= 1; i--) begin
      // ties go left, to the lower way
      if (nd_en[2*i] && (!nd_en[2*i+1] || nd_st[2*i] <= nd_st[2*i+1])) begin
        nd_en[i] = nd_en[2*i];
        nd_st[i] = nd_st[2*i];
        nd_ix[i] = nd_ix[2*i];
      end else begin
        nd_en[i] = nd_en[2*i+1];
        nd_st[i] = nd_st[2*i+1];
        nd_ix[i] = nd_ix[2*i+1];
      end
    end
    lru_way  = nd_ix[1];
    fill_way = any_empty ? empty_way : lru_way;

    clk_cnt_nxt = clk_cnt_r + STAMP_W'(1);

    row_nxt = row;
    if (found) begin
      row_nxt.stamp[hit_way] = clk_cnt_nxt;
    end else begin
      row_nxt.valid[fill_way] = 1'b1;
      row_nxt.tag[fill_way]   = tag_r;
      row_nxt.stamp[fill_way] = clk_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // totals and result
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] hit_mod;
  logic [1:0]       outcome;

  always_comb begin
    hit_mod = hit_cnt_r;
    if (op_r == OP_MODIFY && hit_cnt_r != '1) hit_mod = hit_cnt_r + CNT_W'(1);
    hit_cnt_nxt   = hit_mod;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    outcome       = OUT_IGNORED;
    if (op_r != OP_FETCH) begin
      if (found) begin
        outcome = OUT_HIT;
        if (hit_mod != '1) hit_cnt_nxt = hit_mod + CNT_W'(1);
      end else begin
        outcome = any_empty ? OUT_FILL : OUT_EVICT;
        if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
        if (!any_empty && evict_cnt_r != '1) evict_cnt_nxt = evict_cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_LOOK;
      S_LOOK:  if (adv) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      set_bits_r   <= 4'd0;
      ways_r       <= 4'd1;
      block_bits_r <= 6'd0;
      clk_cnt_r    <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
      row_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits_r   <= cfg_wdata[3:0];
          CFG_WAYS_IN_USE: ways_r       <= cfg_wdata[3:0];
          CFG_BLOCK_BITS:  block_bits_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
        if (op_r != OP_FETCH) clk_cnt_r <= clk_cnt_nxt;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) row_vld_r[idx_r] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_data.opcode;
      idx_r <= set_idx;
      tag_r <= tag_in;
    end
    if (adv) begin
      out_data_r.outcome     <= outcome;
      out_data_r.extra_hit   <= (op_r == OP_MODIFY);
      out_data_r.hit_total   <= hit_cnt_nxt;
      out_data_r.miss_total  <= miss_cnt_nxt;
      out_data_r.evict_total <= evict_cnt_nxt;
    end
  end

  // set memory: one read at transfer, one write-back at the end of lookup for non-fetch accesses
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_r <= mem[set_idx];
      rv_r <= row_vld_r[set_idx];
    end
    if (mem_we) mem[idx_r] <= row_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_we_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_LOOK)
    else $error("set write outside lookup");

  a_xfer_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_LOOK && !in_ready)
    else $error("transfer did not start lookup");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && state_r == S_IDLE)
    else $error("lookup finished without result");

  a_hit_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_cnt_r >= $past(hit_cnt_r))
    else $error("hit total decreased");

  a_fetch_still: assert property (@(posedge clk) disable iff (!rst_n)
    adv && op_r == OP_FETCH |=> $stable(clk_cnt_r) && $stable(miss_cnt_r))
    else $error("fetch changed state");

endmodule

// File: dv/tb_set_assoc_lru_cache_model_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_model_core
// Self-checking bench for the set-associative LRU cache model core.
// ----------------------------------------------------------------------------
// A queue of accesses feeds a valid/ready driver. Each accepted access runs
// through a local cache predictor (tags, valid bits, LRU stamps and totals),
// and every returned result is checked field by field against the oldest
// prediction. Geometry registers are reprogrammed between phases while the
// core is drained, covering out-of-range set and way counts and tag shifts
// of 64 and beyond. Addresses are drawn mostly from small tag/set pools so
// that hits, fills and evictions all occur, with some fully random noise.
module tb_set_assoc_lru_cache_model_core;
  import salc_pkg::*;

  localparam int NUM_LINES   = SET_COUNT * MAX_WAYS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 9;

  // per-phase geometry: set bits, ways, block bits
  localparam int PH_SET_BITS [NUM_PHASES] = '{2, 8, 0, 15, 3, 4, 1, 9, 8};
  localparam int PH_WAYS     [NUM_PHASES] = '{4, 8, 0, 15, 2, 8, 3, 1, 5};
  localparam int PH_BLOCK    [NUM_PHASES] = '{4, 6, 0, 63, 55, 60, 2, 10, 0};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  cache_in_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cache_out_t            out_data;

  set_assoc_lru_cache_model_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial forever #4 clk = ~clk;

  cache_in_t  pending_q [$];
  cache_out_t expected_q [$];

  int send_idle_pct = 18;
  int recv_idle_pct = 58;
  int mismatch_cnt  = 0;
  int cycle_cnt     = 0;
  bit in_fire       = 1'b0;

  // predictor state
  logic [3:0]  geo_set_bits   = 4'd0;
  logic [3:0]  geo_ways       = 4'd1;
  logic [5:0]  geo_block_bits = 6'd0;
  bit          line_ok   [NUM_LINES];
  bit [63:0]   line_tag  [NUM_LINES];
  bit [31:0]   line_age  [NUM_LINES];
  bit [31:0]   access_tick;
  bit [31:0]   hits;
  bit [31:0]   misses;
  bit [31:0]   evictions;

  function automatic bit [31:0] bump_count(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic cache_out_t predict_access(cache_in_t acc);
    int          sbe, nways, shift, base, found, empty, lru, w;
    logic [63:0] idx, tag;
    bit   [31:0] min_age;
    cache_out_t  res;
    res = '0;
    if (acc.opcode != OP_FETCH) begin
      sbe   = (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(geo_set_bits);
      nways = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS) ? MAX_WAYS : int'(geo_ways));
      shift = sbe + int'(geo_block_bits);
      if (acc.opcode == OP_MODIFY) begin
        hits = bump_count(hits);
        res.extra_hit = 1'b1;
      end
      access_tick = access_tick + 32'd1;
      idx  = (acc.address >> geo_block_bits) & ((64'd1 << sbe) - 64'd1);
      tag  = (shift >= 64) ? 64'd0 : (acc.address >> shift);
      base = int'(idx) * MAX_WAYS;
      found = -1;
      empty = -1;
      lru   = 0;
      min_age = line_age[base];
      for (w = 0; w < nways; w++) begin
        if (found < 0) begin
          if (line_ok[base+w] && line_tag[base+w] == tag) begin
            found = w;
          end else begin
            if (!line_ok[base+w] && empty < 0) empty = w;
            if (line_age[base+w] < min_age) begin
              min_age = line_age[base+w];
              lru     = w;
            end
          end
        end
      end
      if (found >= 0) begin
        line_age[base+found] = access_tick;
        hits = bump_count(hits);
        res.outcome = OUT_HIT;
      end else begin
        if (empty >= 0) begin
          lru = empty;
          line_ok[base+lru] = 1'b1;
          res.outcome = OUT_FILL;
        end else begin
          evictions = bump_count(evictions);
          res.outcome = OUT_EVICT;
        end
        line_tag[base+lru] = tag;
        line_age[base+lru] = access_tick;
        misses = bump_count(misses);
      end
    end
    res.hit_total   = hits;
    res.miss_total  = misses;
    res.evict_total = evictions;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: config tracking, result check, prediction of accepted accesses
  always @(posedge clk) begin
    cache_out_t want;
    in_fire = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:    geo_set_bits   = cfg_wdata[3:0];
          CFG_WAYS_IN_USE: geo_ways       = cfg_wdata[3:0];
          CFG_BLOCK_BITS:  geo_block_bits = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: %h", out_data));
        end else begin
          want = expected_q.pop_front();
          if (out_data.outcome !== want.outcome)
            report_mismatch($sformatf("outcome got %0d exp %0d",
                                      out_data.outcome, want.outcome));
          if (out_data.extra_hit !== want.extra_hit)
            report_mismatch($sformatf("extra_hit got %b exp %b",
                                      out_data.extra_hit, want.extra_hit));
          if (out_data.hit_total !== want.hit_total)
            report_mismatch($sformatf("hit_total got %0d exp %0d",
                                      out_data.hit_total, want.hit_total));
          if (out_data.miss_total !== want.miss_total)
            report_mismatch($sformatf("miss_total got %0d exp %0d",
                                      out_data.miss_total, want.miss_total));
          if (out_data.evict_total !== want.evict_total)
            report_mismatch($sformatf("evict_total got %0d exp %0d",
                                      out_data.evict_total, want.evict_total));
        end
      end
      if (in_fire) expected_q.push_back(predict_access(in_data));
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_access(input logic [1:0] op, input logic [63:0] addr);
    cache_in_t acc;
    acc.opcode  = op;
    acc.address = addr;
    pending_q.push_back(acc);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // accesses mostly from a small tag pool over a few sets, so that lines
  // get reused and sets overflow; the rest is fully random noise
  task automatic gen_accesses(input int n, input int sb, input int ways, input int bb);
    logic [63:0] tag_pool [16];
    logic [63:0] set_pool [4];
    logic [63:0] addr, off_mask;
    logic [1:0]  op;
    int          sbe, nways, shift, n_tags, n_sets, done, i;
    sbe      = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
    nways    = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
    shift    = sbe + bb;
    off_mask = (64'd1 << bb) - 64'd1;
    n_tags   = nways + $urandom_range(3);
    n_sets   = $urandom_range(3, 1);
    for (i = 0; i < n_tags; i++) tag_pool[i] = {$urandom, $urandom};
    for (i = 0; i < n_sets; i++) set_pool[i] = $urandom_range((1 << sbe) - 1);
    done = 0;
    while (done < n) begin
      op = 2'($urandom_range(3));
      if ($urandom_range(99) < 15) begin
        addr = {$urandom, $urandom};
      end else begin
        addr = (tag_pool[$urandom_range(n_tags - 1)] << shift)
             | (set_pool[$urandom_range(n_sets - 1)] << bb)
             | ({$urandom, $urandom} & off_mask);
      end
      push_access(op, addr);
      done++;
    end
  endtask

  initial begin
    int p;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: one set, one way, so every new tag after the first fill evicts
    push_access(OP_FETCH,  64'h0);
    push_access(OP_LOAD,   64'h0);
    push_access(OP_LOAD,   64'h0);
    push_access(OP_MODIFY, 64'h0);
    push_access(OP_STORE,  64'hFFFF_FFFF_FFFF_FFFF);
    push_access(OP_FETCH,  64'hFFFF_FFFF_FFFF_FFFF);
    push_access(OP_MODIFY, 64'h8000_0000_0000_0000);
    push_access(OP_LOAD,   64'h8000_0000_0000_0000);
    push_access(OP_LOAD,   64'h5555_5555_5555_5555);
    push_access(OP_STORE,  64'hAAAA_AAAA_AAAA_AAAA);
    push_access(OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
    push_access(OP_FETCH,  64'hAAAA_AAAA_AAAA_AAAA);
    push_access(OP_LOAD,   64'h0000_0000_FFFF_FFFF);
    push_access(OP_STORE,  64'h0000_0000_FFFF_FFFF);
    wait_drained();

    // cache contents carry over from one geometry to the next
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 18;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_SET_BITS,    PH_SET_BITS[p]);
      write_reg(CFG_WAYS_IN_USE, PH_WAYS[p]);
      write_reg(CFG_BLOCK_BITS,  PH_BLOCK[p]);
      gen_accesses(190 + $urandom_range(20), PH_SET_BITS[p], PH_WAYS[p], PH_BLOCK[p]);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/salc_pkg.sv
src/set_assoc_lru_cache_model_core.sv
dv/tb_set_assoc_lru_cache_model_core.sv
